// ===== design/lpht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lpht_pkg;

    localparam int NUM_SLOTS  = 128;
    localparam int KEY_BYTES  = 8;

    localparam int KEY_W      = 64;
    localparam int VALUE_W    = 64;
    localparam int ENTRY_W    = KEY_W + VALUE_W;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int SLOT_OUT_W = 7;
    localparam int EXT_W      = (SLOT_W > SLOT_OUT_W) ? SLOT_W : SLOT_OUT_W;

    // Largest possible byte sum and the width that holds it.
    localparam int SUM_MAX = 255 * KEY_BYTES;
    localparam int SUM_W   = $clog2(SUM_MAX + 1);
    localparam int DIV_W   = (SUM_W > SLOT_W + 1) ? SUM_W : SLOT_W + 1;

    // Number of conditional subtract steps that reduce the byte sum to a slot.
    function automatic int mod_steps();
        int n;
        n = 0;
        for (int k = 0; k < 16; k++)
        begin
            if ((NUM_SLOTS << k) <= SUM_MAX)
            begin
                n = k + 1;
            end
        end
        return (n < 1) ? 1 : n;
    endfunction

    localparam int MOD_STEPS = mod_steps();
    localparam int MODC_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    // Keeps the low KEY_BYTES bytes of a key.
    function automatic logic [KEY_W-1:0] key_mask();
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (b < KEY_BYTES)
            begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    localparam logic [KEY_W-1:0] KEY_MASK = key_mask();

    localparam logic CFG_OVERWRITE = 1'b0;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_KEPT      = 3'd2,
        ST_FULL      = 3'd3,
        ST_FOUND     = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_INVALID   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_MOD,
        S_PROBE,
        S_CMP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic               action;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [VALUE_W-1:0]    value_out;
        logic [SLOT_OUT_W-1:0] slot;
    } rsp_t;

    typedef struct packed {
        logic    load;
        logic    sum;
        logic    mod;
        logic    step;
        logic    rd;
        logic    ins;
        logic    upd;
        logic    res_set;
        status_t res_status;
        logic    res_found;
        logic    res_slot;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic key_zero;
        logic search;
        logic slot_empty;
        logic key_match;
        logic last_probe;
        logic mod_last;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== design/lpht_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== design/lpht_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lpht_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire logic                overwrite,
    input  wire lpht_pkg::dp_status_t st,
    output lpht_pkg::dp_cmd_t         cmd
);

    lpht_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpht_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_status = lpht_pkg::ST_INVALID;
        req_ready  = 1'b0;
        case (state_reg)
            lpht_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lpht_pkg::S_SUM;
                end
            end
            lpht_pkg::S_SUM:
            begin
                if (st.key_zero)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = lpht_pkg::ST_INVALID;
                    state_next     = lpht_pkg::S_DONE;
                end
                else
                begin
                    cmd.sum    = 1'b1;
                    state_next = lpht_pkg::S_MOD;
                end
            end
            lpht_pkg::S_MOD:
            begin
                cmd.mod = 1'b1;
                if (st.mod_last)
                begin
                    state_next = lpht_pkg::S_PROBE;
                end
            end
            lpht_pkg::S_PROBE:
            begin
                if (st.slot_empty)
                begin
                    cmd.res_set = 1'b1;
                    if (st.search)
                    begin
                        cmd.res_status = lpht_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        cmd.ins        = 1'b1;
                        cmd.res_slot   = 1'b1;
                        cmd.res_status = lpht_pkg::ST_INSERTED;
                    end
                    state_next = lpht_pkg::S_DONE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = lpht_pkg::S_CMP;
                end
            end
            lpht_pkg::S_CMP:
            begin
                if (st.key_match)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_slot = 1'b1;
                    if (st.search)
                    begin
                        cmd.res_found  = 1'b1;
                        cmd.res_status = lpht_pkg::ST_FOUND;
                    end
                    else if (overwrite)
                    begin
                        cmd.upd        = 1'b1;
                        cmd.res_status = lpht_pkg::ST_UPDATED;
                    end
                    else
                    begin
                        cmd.res_status = lpht_pkg::ST_KEPT;
                    end
                    state_next = lpht_pkg::S_DONE;
                end
                else if (st.last_probe)
                begin
                    // Every slot has been visited without a match.
                    cmd.res_set    = 1'b1;
                    cmd.res_status = st.search ? lpht_pkg::ST_NOT_FOUND : lpht_pkg::ST_FULL;
                    state_next     = lpht_pkg::S_DONE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = lpht_pkg::S_PROBE;
                end
            end
            lpht_pkg::S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = lpht_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lpht_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/lpht_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lpht_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lpht_pkg::req_t    req,
    output lpht_pkg::rsp_t         rsp,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    input  wire lpht_pkg::dp_cmd_t cmd,
    output lpht_pkg::dp_status_t   st
);

    localparam int SLOT_W = lpht_pkg::SLOT_W;
    localparam int DIV_W  = lpht_pkg::DIV_W;
    localparam int MODC_W = lpht_pkg::MODC_W;
    localparam int KEY_W  = lpht_pkg::KEY_W;

    logic                        action_reg;
    logic [KEY_W-1:0]            key_reg;
    logic [lpht_pkg::VALUE_W-1:0] value_reg;
    logic [DIV_W-1:0]            sum_reg;
    logic [MODC_W-1:0]           mod_cnt_reg;
    logic [SLOT_W-1:0]           pos_reg;
    logic [SLOT_W-1:0]           probe_cnt_reg;
    logic [lpht_pkg::NUM_SLOTS-1:0] valid_reg;
    lpht_pkg::rsp_t              res_reg;
    lpht_pkg::rsp_t              rsp_reg;
    logic                        rsp_valid_reg;

    logic [lpht_pkg::SUM_W-1:0]  byte_sum;
    logic [DIV_W-1:0]            div_val;
    logic [DIV_W-1:0]            sum_next;
    logic [SLOT_W-1:0]           pos_inc;
    logic [lpht_pkg::EXT_W-1:0]  pos_ext;
    logic [lpht_pkg::ENTRY_W-1:0] rdata;

    always_comb
    begin
        byte_sum = '0;
        for (int b = 0; b < lpht_pkg::KEY_BYTES; b++)
        begin
            byte_sum = byte_sum + lpht_pkg::SUM_W'(key_reg[8*b +: 8]);
        end
    end

    // One restoring step of the modulo: subtract the divisor shifted by the step count.
    assign div_val  = DIV_W'(lpht_pkg::NUM_SLOTS) << mod_cnt_reg;
    assign sum_next = (sum_reg >= div_val) ? (sum_reg - div_val) : sum_reg;

    assign pos_inc = (pos_reg == SLOT_W'(lpht_pkg::NUM_SLOTS - 1)) ? '0 : pos_reg + 1'b1;
    assign pos_ext = lpht_pkg::EXT_W'(pos_reg);

    lpht_ram #(
        .WIDTH (lpht_pkg::ENTRY_W),
        .DEPTH (lpht_pkg::NUM_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.ins | cmd.upd),
        .re    (cmd.rd),
        .addr  (pos_reg),
        .wdata ({key_reg, value_reg}),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg    <= req.action;
            key_reg       <= req.key & lpht_pkg::KEY_MASK;
            value_reg     <= req.value;
            probe_cnt_reg <= '0;
        end
        if (cmd.sum)
        begin
            sum_reg     <= DIV_W'(byte_sum);
            mod_cnt_reg <= MODC_W'(lpht_pkg::MOD_STEPS - 1);
        end
        if (cmd.mod)
        begin
            sum_reg     <= sum_next;
            mod_cnt_reg <= mod_cnt_reg - 1'b1;
            pos_reg     <= SLOT_W'(sum_next);
        end
        if (cmd.step)
        begin
            pos_reg       <= pos_inc;
            probe_cnt_reg <= probe_cnt_reg + 1'b1;
        end
        if (cmd.res_set)
        begin
            res_reg.status    <= cmd.res_status;
            res_reg.value_out <= cmd.res_found ? rdata[lpht_pkg::VALUE_W-1:0] : '0;
            res_reg.slot      <= cmd.res_slot ? pos_ext[lpht_pkg::SLOT_OUT_W-1:0] : '0;
        end
        if (cmd.out_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ins)
            begin
                valid_reg[pos_reg] <= 1'b1;
            end
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        st.key_zero   = (key_reg == '0);
        st.search     = (action_reg == lpht_pkg::ACT_SEARCH);
        st.slot_empty = !valid_reg[pos_reg];
        st.key_match  = (rdata[lpht_pkg::ENTRY_W-1 -: KEY_W] == key_reg);
        st.last_probe = (probe_cnt_reg == SLOT_W'(lpht_pkg::NUM_SLOTS - 1));
        st.mod_last   = (mod_cnt_reg == '0);
        st.out_free   = !rsp_valid_reg || rsp_ready;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule
`default_nettype wire

// ===== design/linear_probe_hash_table_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Key/value store of 128 slots with open addressing and linear probing. Each request beat
// is an insert or a search; each gives exactly one response beat. One request is worked on
// at a time: accepting it is followed by a byte-sum step and then one conditional subtract
// per cycle (four at 128 slots) to form the home slot; each occupied slot visited is a key
// RAM read, then a compare, an empty slot a single check, and last the response is handed
// to the output register. Slot valid bits are flip-flops cleared by reset, so no clearing
// pass is needed. A new request may be accepted while the previous response still waits.
// Register 0 (byte address 0), bit 0, selects whether an insert of a present key replaces
// its value; it resets to 1.
module linear_probe_hash_table_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire lpht_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output lpht_pkg::rsp_t      rsp,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic                 overwrite_reg;
    lpht_pkg::dp_cmd_t    cmd;
    lpht_pkg::dp_status_t st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overwrite_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && (paddr[2] == lpht_pkg::CFG_OVERWRITE))
        begin
            overwrite_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == lpht_pkg::CFG_OVERWRITE) ? {31'b0, overwrite_reg} : '0;

    lpht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .overwrite (overwrite_reg),
        .st        (st),
        .cmd       (cmd)
    );

    lpht_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
`default_nettype wire

// ===== design/lpht_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lpht_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_ready,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire lpht_pkg::rsp_t rsp,
    input wire logic           psel,
    input wire logic           pready
);

    // A stalled response beat must hold.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    // Only one request is in work at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in work");

    a_value_only_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != lpht_pkg::ST_FOUND) |-> rsp.value_out == '0)
        else $error("value returned without a hit");

    a_slot_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == lpht_pkg::ST_FULL || rsp.status == lpht_pkg::ST_NOT_FOUND
            || rsp.status == lpht_pkg::ST_INVALID) |-> rsp.slot == '0)
        else $error("slot reported for a response without a slot");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
        else $error("configuration access stalled");

endmodule

bind linear_probe_hash_table_top lpht_checker u_checker (.*);
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

    localparam int QUIET_LIMIT = 3000;
    localparam int IDLE_PCT    = 36;
    localparam logic [2:0] OVERWRITE_ADDR = 3'(4 * lpht_pkg::CFG_OVERWRITE);
    localparam logic [2:0] SPARE_ADDR     = 3'd4;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    lpht_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    lpht_pkg::rsp_t rsp;
    logic           psel      = 1'b0;
    logic           penable   = 1'b0;
    logic           pwrite    = 1'b0;
    logic [2:0]     paddr     = '0;
    logic [31:0]    pwdata    = '0;
    logic [31:0]    prdata;
    logic           pready;

    lpht_pkg::req_t               op_queue[$];
    lpht_pkg::rsp_t               outcome_queue[$];
    lpht_pkg::rsp_t               due_rsp;
    logic [lpht_pkg::KEY_W-1:0]   key_pool[$];
    bit                           occupied[lpht_pkg::NUM_SLOTS];
    logic [lpht_pkg::KEY_W-1:0]   stored_key[lpht_pkg::NUM_SLOTS];
    logic [lpht_pkg::VALUE_W-1:0] stored_value[lpht_pkg::NUM_SLOTS];
    bit                           replace_on_insert = 1'b1;
    bit                           no_gaps = 1'b0;
    int                           errors = 0;
    int                           n_ops = 0;
    int                           quiet = 0;
    int                           status_seen[8];

    linear_probe_hash_table_top dut (.*);

    always #5 clk = ~clk;

    // Walks the table exactly as the block does and applies any change to it.
    function automatic lpht_pkg::rsp_t probe_table(input lpht_pkg::req_t op);
        logic [lpht_pkg::KEY_W-1:0] k;
        int                         total;
        int                         pos;
        bit                         done;
        lpht_pkg::rsp_t             res;
        k = op.key & lpht_pkg::KEY_MASK;
        res.value_out = '0;
        res.slot = '0;
        res.status = lpht_pkg::ST_INVALID;
        if (k != '0)
        begin
            total = 0;
            for (int b = 0; b < 8; b++)
            begin
                total += k[8*b +: 8];
            end
            pos = total % lpht_pkg::NUM_SLOTS;
            res.status = (op.action == lpht_pkg::ACT_SEARCH) ? lpht_pkg::ST_NOT_FOUND
                                                              : lpht_pkg::ST_FULL;
            done = 1'b0;
            for (int n = 0; n < lpht_pkg::NUM_SLOTS && !done; n++)
            begin
                if (!occupied[pos])
                begin
                    if (op.action == lpht_pkg::ACT_INSERT)
                    begin
                        occupied[pos] = 1'b1;
                        stored_key[pos] = k;
                        stored_value[pos] = op.value;
                        res.status = lpht_pkg::ST_INSERTED;
                        res.slot = lpht_pkg::SLOT_OUT_W'(pos);
                    end
                    done = 1'b1;
                end
                else if (stored_key[pos] == k)
                begin
                    if (op.action == lpht_pkg::ACT_SEARCH)
                    begin
                        res.status = lpht_pkg::ST_FOUND;
                        res.value_out = stored_value[pos];
                    end
                    else if (replace_on_insert)
                    begin
                        stored_value[pos] = op.value;
                        res.status = lpht_pkg::ST_UPDATED;
                    end
                    else
                    begin
                        res.status = lpht_pkg::ST_KEPT;
                    end
                    res.slot = lpht_pkg::SLOT_OUT_W'(pos);
                    done = 1'b1;
                end
                else
                begin
                    pos = (pos + 1) % lpht_pkg::NUM_SLOTS;
                end
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Keys come in several shapes; byte rotations of a known key share its home slot,
    // which builds up collision chains.
    function automatic logic [lpht_pkg::KEY_W-1:0] fresh_key();
        logic [lpht_pkg::KEY_W-1:0] k;
        int                         n;
        k = '0;
        case ($urandom_range(3))
            0:
            begin
                k = rand64();
            end
            1:
            begin
                n = $urandom_range(2);
                for (int b = 0; b <= n; b++)
                begin
                    k[8*b +: 8] = 8'($urandom);
                end
            end
            2:
            begin
                if (key_pool.size() != 0)
                begin
                    k = key_pool[$urandom_range(key_pool.size() - 1)];
                    n = 8 * $urandom_range(1, 7);
                    k = (k << n) | (k >> (64 - n));
                end
                else
                begin
                    k = rand64();
                end
            end
            default:
            begin
                k = 64'($urandom_range(255)) << (8 * $urandom_range(7));
            end
        endcase
        if (k == '0)
        begin
            k = 64'd1;
        end
        return k;
    endfunction

    task automatic queue_op(input logic act, input logic [lpht_pkg::KEY_W-1:0] k,
                            input logic [lpht_pkg::VALUE_W-1:0] v);
        lpht_pkg::req_t op;
        op.action = act;
        op.key = k;
        op.value = v;
        op_queue.push_back(op);
    endtask

    // Mostly keys already in play, so that hits, updates and collisions dominate.
    task automatic queue_random(input int count);
        int                         r;
        logic                       act;
        logic [lpht_pkg::KEY_W-1:0] k;
        @(negedge clk);
        repeat (count)
        begin
            r = $urandom_range(99);
            if (r < 4)
            begin
                k = '0;
                act = 1'($urandom_range(1));
            end
            else if (r < 86)
            begin
                k = key_pool[$urandom_range(key_pool.size() - 1)];
                act = (r < 48) ? lpht_pkg::ACT_INSERT : lpht_pkg::ACT_SEARCH;
            end
            else
            begin
                k = fresh_key();
                act = 1'($urandom_range(1));
                if (act == lpht_pkg::ACT_INSERT)
                begin
                    key_pool.push_back(k);
                end
            end
            queue_op(act, k, rand64());
        end
    endtask

    // Inserts distinct absent keys until every slot is taken, plus a few that find it full.
    task automatic fill_table();
        int                         free_slots;
        bit                         clash;
        logic [lpht_pkg::KEY_W-1:0] k;
        bit                         chosen[logic [lpht_pkg::KEY_W-1:0]];
        free_slots = 0;
        foreach (occupied[i])
        begin
            if (!occupied[i])
            begin
                free_slots++;
            end
        end
        @(negedge clk);
        repeat (free_slots + 3)
        begin
            do
            begin
                k = fresh_key();
                clash = chosen.exists(k);
                foreach (occupied[i])
                begin
                    if (occupied[i] && stored_key[i] == k)
                    begin
                        clash = 1'b1;
                    end
                end
            end
            while (clash);
            chosen[k] = 1'b1;
            key_pool.push_back(k);
            queue_op(lpht_pkg::ACT_INSERT, k, rand64());
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (op_queue.size() != 0 || req_valid || outcome_queue.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == OVERWRITE_ADDR)
        begin
            replace_on_insert = data[0];
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                outcome_queue.push_back(probe_table(req));
                n_ops++;
            end
            if (!req_valid || req_ready)
            begin
                if (op_queue.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT))
                begin
                    req_valid <= 1'b1;
                    req <= op_queue.pop_front();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
            if (rsp_valid && rsp_ready)
            begin
                status_seen[rsp.status]++;
                if (outcome_queue.size() == 0)
                begin
                    $error("response beat with no request outstanding: status %0d", rsp.status);
                    errors++;
                end
                else
                begin
                    due_rsp = outcome_queue.pop_front();
                    if (rsp.status !== due_rsp.status)
                    begin
                        $error("status: expected %0d, actual %0d", due_rsp.status, rsp.status);
                        errors++;
                    end
                    if (rsp.value_out !== due_rsp.value_out)
                    begin
                        $error("value_out: expected %h, actual %h",
                               due_rsp.value_out, rsp.value_out);
                        errors++;
                    end
                    if (rsp.slot !== due_rsp.slot)
                    begin
                        $error("slot: expected %0d, actual %0d", due_rsp.slot, rsp.slot);
                        errors++;
                    end
                end
            end
        end
    end

    // Gives up once neither channel nor the register port has moved for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
            begin
                quiet <= 0;
            end
            else
            begin
                quiet <= quiet + 1;
            end
            if (quiet >= QUIET_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Zero keys, empty table, a collision, an update, the top slot wrapping to slot 0.
        @(negedge clk);
        queue_op(lpht_pkg::ACT_SEARCH, 64'd0, rand64());
        queue_op(lpht_pkg::ACT_INSERT, 64'd0, '1);
        queue_op(lpht_pkg::ACT_SEARCH, 64'd1, '1);
        queue_op(lpht_pkg::ACT_INSERT, 64'd1, '1);
        queue_op(lpht_pkg::ACT_INSERT, 64'h100, 64'h5555_5555_5555_5555);
        queue_op(lpht_pkg::ACT_SEARCH, 64'h100, '0);
        queue_op(lpht_pkg::ACT_INSERT, 64'd1, '0);
        queue_op(lpht_pkg::ACT_SEARCH, 64'd1, rand64());
        queue_op(lpht_pkg::ACT_INSERT, '1, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_op(lpht_pkg::ACT_SEARCH, '1, '0);
        queue_op(lpht_pkg::ACT_INSERT, 64'h7F, rand64());
        queue_op(lpht_pkg::ACT_INSERT, 64'h7F00, rand64());
        queue_op(lpht_pkg::ACT_SEARCH, 64'h7F00, '0);
        queue_op(lpht_pkg::ACT_INSERT, 64'h8000_0000_0000_0000, rand64());
        queue_op(lpht_pkg::ACT_SEARCH, 64'hFF, rand64());
        wait_drained();
        write_reg(OVERWRITE_ADDR, 32'd0);
        @(negedge clk);
        queue_op(lpht_pkg::ACT_INSERT, 64'd1, 64'h1234);
        queue_op(lpht_pkg::ACT_SEARCH, 64'd1, '0);
        wait_drained();
        // Only bit 0 counts, and a write to an unused address changes nothing.
        write_reg(OVERWRITE_ADDR, 32'hFFFF_FFFE);
        write_reg(SPARE_ADDR, 32'd1);
        @(negedge clk);
        queue_op(lpht_pkg::ACT_INSERT, 64'h100, rand64());
        wait_drained();
        write_reg(OVERWRITE_ADDR, 32'd1);

        repeat (12)
        begin
            key_pool.push_back(fresh_key());
        end
        queue_random(550);
        wait_drained();

        write_reg(OVERWRITE_ADDR, 32'd0);
        no_gaps = 1'b1;
        queue_random(350);
        wait_drained();
        no_gaps = 1'b0;

        write_reg(OVERWRITE_ADDR, 32'hFFFF_FFFF);
        fill_table();
        wait_drained();

        // From here on every absent key walks the whole table.
        write_reg(OVERWRITE_ADDR, 32'd0);
        queue_random(360);
        wait_drained();
        write_reg(SPARE_ADDR, 32'd0);
        write_reg(OVERWRITE_ADDR, 32'd1);
        queue_random(360);
        wait_drained();
        repeat (30) @(posedge clk);

        $display("%0d requests: %0d inserted, %0d updated, %0d kept, %0d with the table full",
                 n_ops, status_seen[lpht_pkg::ST_INSERTED], status_seen[lpht_pkg::ST_UPDATED],
                 status_seen[lpht_pkg::ST_KEPT], status_seen[lpht_pkg::ST_FULL]);
        $display("%0d found, %0d not found, %0d zero keys; overwrite on and off, %0d errors",
                 status_seen[lpht_pkg::ST_FOUND], status_seen[lpht_pkg::ST_NOT_FOUND],
                 status_seen[lpht_pkg::ST_INVALID], errors);
        if (errors == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lpht_pkg.sv
design/lpht_ram.sv
design/lpht_ctrl.sv
design/lpht_datapath.sv
design/linear_probe_hash_table_top.sv
design/lpht_checker.sv
sim/tb_top.sv
